// ===== rtl/mas_pkg.sv =====
package mas_pkg;

	// register field and result index widths
	localparam int CFG_W     = 4;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int IDX_W     = 3;

	// register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 2'd3;

	// operation codes; the upper bit alone selects multiply
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RST = 4'd8;

	typedef enum logic [2:0] {
		ST_LOAD_A,
		ST_LOAD_B,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} state_t;

	// control that follows a read through the arithmetic pipeline
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		logic mul;
		logic sub;
	} pipe_ctl_t;

	typedef struct packed {
		logic      wr_a;
		logic      wr_b;
		pipe_ctl_t rd;
	} dp_cmd_t;

endpackage

// ===== rtl/mas_dp.sv =====
module mas_dp #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mas_pkg::dp_cmd_t      cmd,
	input  logic [AW-1:0]         wr_addr,
	input  logic [AW-1:0]         rd_a_addr,
	input  logic [AW-1:0]         rd_b_addr,
	input  logic [DATA_WIDTH-1:0] din,
	output logic [DATA_WIDTH-1:0] acc,
	output logic                  done
);
	import mas_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int LO_W  = DATA_WIDTH / 2;
	localparam int HI_W  = DATA_WIDTH - LO_W;

	logic [DATA_WIDTH-1:0] mem_a [0:DEPTH-1];
	logic [DATA_WIDTH-1:0] mem_b [0:DEPTH-1];

	logic [DATA_WIDTH-1:0] a_s1, b_s1;
	pipe_ctl_t             ctl_s1, ctl_s2, ctl_s3;

	logic [2*LO_W-1:0]     m_ll;
	logic [DATA_WIDTH-1:0] m_lh, m_hl;
	logic [2*LO_W-1:0]     ll_s2;
	logic [HI_W-1:0]       x_s2;
	logic [DATA_WIDTH-1:0] sum_s2;

	logic [DATA_WIDTH-1:0] prod_s3, sum_s3;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  done_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_a) mem_a[wr_addr] <= din;
		if (cmd.wr_b) mem_b[wr_addr] <= din;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd.vld) begin
			a_s1 <= mem_a[rd_a_addr];
			b_s1 <= mem_b[rd_b_addr];
		end
	end

	// product modulo the word: low halves in full, cross terms only in the upper half
	assign m_ll = a_s1[LO_W-1:0] * b_s1[LO_W-1:0];
	assign m_lh = a_s1[LO_W-1:0] * b_s1[DATA_WIDTH-1:LO_W];
	assign m_hl = a_s1[DATA_WIDTH-1:LO_W] * b_s1[LO_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			ll_s2  <= m_ll;
			x_s2   <= m_lh[HI_W-1:0] + m_hl[HI_W-1:0];
			sum_s2 <= ctl_s1.sub ? (a_s1 - b_s1) : (a_s1 + b_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			prod_s3 <= DATA_WIDTH'(ll_s2) + {x_s2, {LO_W{1'b0}}};
			sum_s3  <= sum_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.vld) begin
			if (ctl_s3.mul) acc_q <= ctl_s3.first ? prod_s3 : (acc_q + prod_s3);
			else acc_q <= sum_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= cmd.rd;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.vld && ctl_s3.last;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== rtl/mas_ctrl.sv =====
module mas_ctrl #(
	parameter int MAX_DIM = 8,
	parameter int AW      = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [mas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mas_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            elem_valid,
	output logic                            elem_stall,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [mas_pkg::IDX_W-1:0]       res_row,
	output logic [mas_pkg::IDX_W-1:0]       res_col,
	output logic                            res_last,
	output mas_pkg::dp_cmd_t                cmd,
	output logic [AW-1:0]                   wr_addr,
	output logic [AW-1:0]                   rd_a_addr,
	output logic [AW-1:0]                   rd_b_addr,
	input  logic                            dp_done
);
	import mas_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int LEN_W = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > MAX_DIM) r = DIM_W'(MAX_DIM);
		else r = DIM_W'(v);
		return r;
	endfunction

	logic [MODE_W-1:0] op_mode_q;
	logic [CFG_W-1:0]  rows_a_q, cols_a_q, cols_b_q;

	state_t state_q, state_d;

	logic [AW-1:0] load_cnt_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] a_base_q, b_run_q;

	logic [DIM_W-1:0] ra, ca, cb, rc;
	logic             mul;
	logic [LEN_W-1:0] a_len, b_len;
	logic             a_last, b_last, k_last, i_last, j_last, elem_last;
	logic             in_load, restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_MUL;
			rows_a_q  <= DIM_RST;
			cols_a_q  <= DIM_RST;
			cols_b_q  <= DIM_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_OP_MODE: op_mode_q <= cfg_wdata[MODE_W-1:0];
				REG_ROWS_A:  rows_a_q  <= cfg_wdata;
				REG_COLS_A:  cols_a_q  <= cfg_wdata;
				REG_COLS_B:  cols_b_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ra  = clamp_dim(rows_a_q);
	assign ca  = clamp_dim(cols_a_q);
	assign cb  = clamp_dim(cols_b_q);
	assign mul = op_mode_q[1];
	assign rc  = mul ? cb : ca;

	assign a_len = LEN_W'(ra) * LEN_W'(ca);
	assign b_len = mul ? (LEN_W'(ca) * LEN_W'(cb)) : a_len;

	assign a_last    = LEN_W'(load_cnt_q) == a_len - LEN_W'(1);
	assign b_last    = LEN_W'(load_cnt_q) == b_len - LEN_W'(1);
	assign k_last    = !mul || (DIM_W'(k_q) == ca - DIM_W'(1));
	assign i_last    = DIM_W'(i_q) == ra - DIM_W'(1);
	assign j_last    = DIM_W'(j_q) == rc - DIM_W'(1);
	assign elem_last = i_last && j_last;

	assign in_load = (state_q == ST_LOAD_A) || (state_q == ST_LOAD_B);
	// a register write throws away a partial load
	assign restart = cfg_wr_en && in_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD_A;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		elem_stall  = 1'b1;
		cmd         = '0;
		cmd.rd.mul  = mul;
		cmd.rd.sub  = op_mode_q[0];
		cmd.rd.first = (k_q == '0);
		cmd.rd.last = k_last;
		case (state_q)
			ST_LOAD_A: begin
				elem_stall = 1'b0;
				cmd.wr_a   = elem_valid;
				if (elem_valid && a_last) state_d = ST_LOAD_B;
			end
			ST_LOAD_B: begin
				elem_stall = 1'b0;
				cmd.wr_b   = elem_valid;
				if (elem_valid && b_last) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.rd.vld = 1'b1;
				if (k_last) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (dp_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_stall) state_d = elem_last ? ST_LOAD_A : ST_ISSUE;
			end
			default: state_d = ST_LOAD_A;
		endcase
		if (restart) state_d = ST_LOAD_A;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			a_base_q   <= '0;
			b_run_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD_A, ST_LOAD_B: begin
					i_q      <= '0;
					j_q      <= '0;
					k_q      <= '0;
					a_base_q <= '0;
					b_run_q  <= '0;
					if (restart) load_cnt_q <= '0;
					else if (elem_valid) begin
						if ((state_q == ST_LOAD_A) ? a_last : b_last) load_cnt_q <= '0;
						else load_cnt_q <= load_cnt_q + AW'(1);
					end
				end
				ST_ISSUE: begin
					k_q     <= k_last ? '0 : (k_q + IW'(1));
					// walk down a column of B
					b_run_q <= b_run_q + AW'(cb);
				end
				ST_OUT: begin
					if (!res_stall) begin
						if (j_last) begin
							j_q      <= '0;
							i_q      <= i_q + IW'(1);
							a_base_q <= a_base_q + AW'(ca);
							b_run_q  <= '0;
						end else begin
							j_q     <= j_q + IW'(1);
							b_run_q <= AW'(j_q) + AW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign wr_addr   = load_cnt_q;
	assign rd_a_addr = a_base_q + (mul ? AW'(k_q) : AW'(j_q));
	assign rd_b_addr = mul ? b_run_q : rd_a_addr;

	assign res_valid = (state_q == ST_OUT);
	assign res_row   = IDX_W'(i_q);
	assign res_col   = IDX_W'(j_q);
	assign res_last  = elem_last;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dp_done |-> (state_q == ST_WAIT))
		else $error("datapath finished an element outside the wait state");

	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res_last) |=> (state_q == ST_LOAD_A && load_cnt_q == '0))
		else $error("final result word did not return to loading A");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD_A) |-> (LEN_W'(load_cnt_q) < a_len))
		else $error("load count ran past the size of A");

endmodule

// ===== rtl/matrix_add_sub_multiply_core.sv =====
// Matrix add, subtract and multiply on signed words. Words enter one per cycle on the elem
// channel while loading: A row-major (rows_a by cols_a), then B row-major (A's shape for add
// and subtract, cols_a by cols_b for multiply). The word that completes B starts the
// computation and the input stalls until the whole result has left, row-major, with row,
// column and a last mark on the final word. Arithmetic wraps at DATA_WIDTH bits. A register
// write while loading restarts at the first word of A; dimensions of 0 act as 1 and values
// above MAX_DIM act as MAX_DIM. Each result word is built by reading one term at a time from
// both operand memories through their single read ports, draining the read, two-stage
// multiply and accumulate pipeline, and holding the word in the output register.
module matrix_add_sub_multiply_core #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mas_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                elem_valid,
	output logic                                elem_stall,
	input  logic signed [DATA_WIDTH-1:0]        elem_value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [DATA_WIDTH-1:0]        res_value,
	output logic [mas_pkg::IDX_W-1:0]           res_row,
	output logic [mas_pkg::IDX_W-1:0]           res_col,
	output logic                                res_last
);
	import mas_pkg::*;

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	dp_cmd_t               cmd;
	logic [AW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
	logic [DATA_WIDTH-1:0] acc;
	logic                  dp_done;

	mas_ctrl #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_row    (res_row),
		.res_col    (res_col),
		.res_last   (res_last),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_a_addr  (rd_a_addr),
		.rd_b_addr  (rd_b_addr),
		.dp_done    (dp_done)
	);

	mas_dp #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.din       (elem_value),
		.acc       (acc),
		.done      (dp_done)
	);

	assign res_value = acc;

endmodule

// ===== verif/matrix_add_sub_multiply_core_test.sv =====
module matrix_add_sub_multiply_core_test;
	import mas_pkg::*;

	localparam int DW = 32;
	localparam int DIM_MAX = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [MODE_W-1:0] MODE_MUL_ALT = 2'd3;

	typedef struct {
		logic [DW-1:0]    value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} res_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  elem_valid;
	logic                  elem_stall;
	logic signed [DW-1:0]  elem_value;
	logic                  res_valid;
	logic                  res_stall;
	logic signed [DW-1:0]  res_value;
	logic [IDX_W-1:0]      res_row;
	logic [IDX_W-1:0]      res_col;
	logic                  res_last;

	// shadow of the block: register copies, operand stores and load position
	logic [MODE_W-1:0] cur_mode;
	logic [CFG_W-1:0]  cur_rows;
	logic [CFG_W-1:0]  cur_cols_a;
	logic [CFG_W-1:0]  cur_cols_b;
	logic [DW-1:0]     shadow_a [DIM_MAX*DIM_MAX];
	logic [DW-1:0]     shadow_b [DIM_MAX*DIM_MAX];
	int                fill_count;
	logic              filling_b;

	res_word_t result_words [$];
	res_word_t want;
	int        mismatch_count;
	int        words_sent;
	int        idle_pct;
	int        stall_pct;
	int        quiet_cycles;

	matrix_add_sub_multiply_core #(
		.MAX_DIM(DIM_MAX),
		.DATA_WIDTH(DW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.elem_value(elem_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_value(res_value),
		.res_row(res_row),
		.res_col(res_col),
		.res_last(res_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [CFG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > DIM_MAX)
			return DIM_MAX;
		return int'(d);
	endfunction

	function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		case (idx)
			REG_OP_MODE: cur_mode = val[MODE_W-1:0];
			REG_ROWS_A:  cur_rows = val;
			REG_COLS_A:  cur_cols_a = val;
			REG_COLS_B:  cur_cols_b = val;
			default: ;
		endcase
		fill_count = 0;
		filling_b = 1'b0;
	endfunction

	// words needed for one full A and B under the current registers
	function automatic int words_per_set();
		int ra;
		int ca;
		int cb;
		ra = eff_dim(cur_rows);
		ca = eff_dim(cur_cols_a);
		cb = eff_dim(cur_cols_b);
		if (cur_mode[1])
			return ra * ca + ca * cb;
		return 2 * ra * ca;
	endfunction

	// store one loaded word; the word completing B queues the whole result matrix
	function automatic void load_and_compute(input logic [DW-1:0] v);
		int ra;
		int ca;
		int cb;
		int r_cols;
		int b_len;
		logic mul;
		logic [DW-1:0] acc;
		res_word_t w;
		ra = eff_dim(cur_rows);
		ca = eff_dim(cur_cols_a);
		cb = eff_dim(cur_cols_b);
		mul = cur_mode[1];
		r_cols = mul ? cb : ca;
		b_len = mul ? ca * cb : ra * ca;
		if (!filling_b) begin
			shadow_a[fill_count] = v;
			fill_count++;
			if (fill_count >= ra * ca) begin
				fill_count = 0;
				filling_b = 1'b1;
			end
			return;
		end
		shadow_b[fill_count] = v;
		fill_count++;
		if (fill_count < b_len)
			return;
		fill_count = 0;
		filling_b = 1'b0;
		for (int i = 0; i < ra; i++) begin
			for (int j = 0; j < r_cols; j++) begin
				if (mul) begin
					acc = '0;
					for (int k = 0; k < ca; k++)
						acc = acc + shadow_a[i*ca+k] * shadow_b[k*cb+j];
				end else if (!cur_mode[0]) begin
					acc = shadow_a[i*ca+j] + shadow_b[i*ca+j];
				end else begin
					acc = shadow_a[i*ca+j] - shadow_b[i*ca+j];
				end
				w.value = acc;
				w.row = IDX_W'(i);
				w.col = IDX_W'(j);
				w.last = (i == ra - 1) && (j == r_cols - 1);
				result_words.push_back(w);
			end
		end
	endfunction

	function automatic logic [DW-1:0] rand_word();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return {DW{1'b1}};
			2: return {1'b0, {(DW-1){1'b1}}};
			3: return {1'b1, {(DW-1){1'b0}}};
			default: return $urandom;
		endcase
	endfunction

	// mostly small sizes, now and then zero, a larger size up to full size or a saturating value
	function automatic logic [CFG_W-1:0] rand_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return CFG_W'($urandom_range(1, 3));
		if (r < 88)
			return '0;
		if (r < 96)
			return CFG_W'($urandom_range(4, DIM_MAX));
		return CFG_W'($urandom_range(DIM_MAX + 1, 15));
	endfunction

	task automatic send_elem(input logic [DW-1:0] v);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			elem_valid <= 1'b0;
			@(negedge clk);
		end
		elem_valid <= 1'b1;
		elem_value <= v;
		@(posedge clk);
		while (elem_stall)
			@(posedge clk);
		load_and_compute(v);
		words_sent++;
		@(negedge clk);
	endtask

	// leaves the write enable high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		shadow_reg_write(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] rows,
			input logic [CFG_W-1:0] cols_a, input logic [CFG_W-1:0] cols_b);
		write_reg(REG_OP_MODE, CFG_W'(mode));
		write_reg(REG_ROWS_A, rows);
		write_reg(REG_COLS_A, cols_a);
		write_reg(REG_COLS_B, cols_b);
		cfg_wr_en <= 1'b0;
	endtask

	// wait for all results, then give the block time to go quiet
	task automatic settle();
		elem_valid <= 1'b0;
		while (result_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		// multiply under the reset mode and cols_a: one row of A against one column of B
		write_reg(REG_ROWS_A, 4'd1);
		write_reg(REG_COLS_B, 4'd1);
		cfg_wr_en <= 1'b0;
		for (int i = 0; i < 2 * DIM_MAX; i++)
			send_elem(rand_word());
	endtask

	task automatic test_add_wrap();
		settle();
		configure(MODE_ADD, 4'd1, 4'd2, 4'd5);
		send_elem(32'h7fff_ffff);
		send_elem(32'h8000_0000);
		send_elem(32'h0000_0001);
		send_elem(32'hffff_ffff);
	endtask

	task automatic test_sub_wrap();
		settle();
		configure(MODE_SUB, 4'd2, 4'd1, 4'd3);
		send_elem(32'h8000_0000);
		send_elem(32'h0000_0000);
		send_elem(32'h0000_0001);
		send_elem(32'h8000_0000);
	endtask

	task automatic test_mul_wrap();
		settle();
		configure(MODE_MUL, 4'd1, 4'd2, 4'd1);
		send_elem(32'h7fff_ffff);
		send_elem(32'h8000_0000);
		send_elem(32'h7fff_ffff);
		send_elem(32'hffff_ffff);
	endtask

	task automatic test_mode_three_restart();
		settle();
		configure(MODE_MUL_ALT, 4'd1, 4'd1, 4'd2);
		send_elem(32'd5);
		send_elem(32'd9);
		// a write in the middle of B throws the partial load away
		settle();
		write_reg(REG_COLS_B, 4'd2);
		cfg_wr_en <= 1'b0;
		send_elem(32'd3);
		send_elem(-32'sd5);
		send_elem(32'd7);
	endtask

	task automatic test_dim_clamp();
		// zero acts as one, fifteen saturates to full size
		settle();
		configure(MODE_MUL, 4'd0, 4'd0, 4'd15);
		for (int i = 0; i < 1 + DIM_MAX; i++)
			send_elem(rand_word());
	endtask

	task automatic run_random_set();
		int n;
		settle();
		configure(MODE_W'($urandom_range(0, 3)), rand_dim(), rand_dim(), rand_dim());
		n = words_per_set();
		// now and then a broken set; the next register write restarts the load
		if (n > 1 && $urandom_range(0, 9) == 0)
			n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++)
			send_elem(rand_word());
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int quota);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = words_sent;
		while (words_sent - start < quota)
			run_random_set();
	endtask

	always @(negedge clk)
		res_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (result_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: value %0d row %0d col %0d last %0b",
						res_value, res_row, res_col, res_last);
			end else begin
				want = result_words.pop_front();
				if (res_value !== want.value || res_row !== want.row ||
						res_col !== want.col || res_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result mismatch: expected value %0d row %0d col %0d last %0b",
							$signed(want.value), want.row, want.col, want.last);
						$display("  got value %0d row %0d col %0d last %0b",
							res_value, res_row, res_col, res_last);
					end
				end
			end
		end
	end

	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((elem_valid && !elem_stall) || (res_valid && !res_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("matrix_add_sub_multiply_core test failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		elem_valid = 1'b0;
		elem_value = '0;
		res_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		words_sent = 0;
		cur_mode = MODE_MUL;
		cur_rows = DIM_RST;
		cur_cols_a = DIM_RST;
		cur_cols_b = DIM_RST;
		fill_count = 0;
		filling_b = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_add_wrap();
		test_sub_wrap();
		test_mul_wrap();
		test_mode_three_restart();
		test_dim_clamp();
		test_random_phase(0, 0, 12);
		test_random_phase(46, 0, 12);
		test_random_phase(0, 46, 12);
		test_random_phase(14, 14, 12);

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && result_words.size() == 0)
			$display("matrix_add_sub_multiply_core test passed");
		else
			$display("matrix_add_sub_multiply_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mas_pkg.sv
rtl/mas_dp.sv
rtl/mas_ctrl.sv
rtl/matrix_add_sub_multiply_core.sv
verif/matrix_add_sub_multiply_core_test.sv
